### hw/rtl/gbs_pkg.sv
// Shared types, constants and command codes for the Gini best-split search block.
package gbs_pkg;

	localparam int MAX_SAMPLES_DEF = 256;
	localparam int NUM_CLASSES = 8;
	localparam int FRAC_BITS = 16;
	localparam int VALUE_W = 16;
	localparam int LABEL_W = 3;
	localparam int CLASS_W = 4;
	localparam int THR_W = 17;
	localparam int SCORE_OUT_W = 24;
	localparam logic [CLASS_W-1:0] CLASS_COUNT_RESET = 4'd2;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [LABEL_W-1:0] label;
	} entry_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_SORT_RDI,
		ST_SORT_KEY,
		ST_SORT_RDJ,
		ST_SORT_CMP,
		ST_CNT_RD,
		ST_CNT_ADD,
		ST_SC_SQ,
		ST_SC_NUM,
		ST_SC_DIV,
		ST_SC_END,
		ST_SCAN_INIT,
		ST_SCAN_CUR,
		ST_SCAN_RD,
		ST_SCAN_UPD,
		ST_SCAN_CMP,
		ST_FINISH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_SORT_RDI,
		OP_SORT_KEY,
		OP_SORT_RDJ,
		OP_SORT_CMP,
		OP_CNT_RD,
		OP_CNT_ADD,
		OP_SC_SQ,
		OP_SC_NUM,
		OP_SC_DIV,
		OP_SC_END,
		OP_SCAN_INIT,
		OP_SCAN_CUR,
		OP_SCAN_RD,
		OP_SCAN_UPD,
		OP_SCAN_CMP,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [1:0] {
		SIDE_FULL,
		SIDE_LEFT,
		SIDE_RIGHT
	} side_t;

	typedef struct packed {
		dp_op_t op;
		side_t  side;
	} dp_cmd_t;

	typedef struct packed {
		logic last_fire;
		logic n_lt2;
		logic j_zero;
		logic i_last;
		logic shift;
		logic same;
		logic scan_last;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

### hw/rtl/gbs_sample_if.sv
// Sample channel interface: one node sample per transaction.
interface gbs_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gbs_pkg::VALUE_W-1:0]   feature_value;
	logic        [gbs_pkg::LABEL_W-1:0]   class_label;
	logic                                 last_sample;

	modport source(output valid, feature_value, class_label, last_sample, input ready);
	modport sink(input valid, feature_value, class_label, last_sample, output ready);
endinterface

### hw/rtl/gbs_result_if.sv
// Result channel interface: one split decision per transaction.
interface gbs_result_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   split_found;
	logic signed [gbs_pkg::THR_W-1:0]       threshold_sum;
	logic        [gbs_pkg::SCORE_OUT_W-1:0] best_impurity;
	logic        [gbs_pkg::SCORE_OUT_W-1:0] split_gain;
	logic                                   overflowed;
	logic                                   bad_label;

	modport source(output valid, split_found, threshold_sum, best_impurity, split_gain,
		overflowed, bad_label, input ready);
	modport sink(input valid, split_found, threshold_sum, best_impurity, split_gain,
		overflowed, bad_label, output ready);
endinterface

### hw/rtl/gbs_ctrl.sv
// Sequencing state machine for loading, sorting, counting, scoring and scanning.
module gbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  gbs_pkg::dp_status_t status,
	output gbs_pkg::dp_cmd_t    cmd
);
	import gbs_pkg::*;

	state_t state_q, state_d;
	side_t  side_q, side_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			side_q  <= SIDE_FULL;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
		end
	end

	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		case (state_q)
			ST_LOAD: begin
				if (status.last_fire) state_d = ST_START;
			end
			ST_START: begin
				state_d = status.n_lt2 ? ST_FINISH : ST_SORT_RDI;
			end
			ST_SORT_RDI: state_d = ST_SORT_KEY;
			ST_SORT_KEY: state_d = ST_SORT_RDJ;
			ST_SORT_RDJ: begin
				if (!status.j_zero) state_d = ST_SORT_CMP;
				else state_d = status.i_last ? ST_CNT_RD : ST_SORT_RDI;
			end
			ST_SORT_CMP: begin
				if (status.shift) state_d = ST_SORT_RDJ;
				else state_d = status.i_last ? ST_CNT_RD : ST_SORT_RDI;
			end
			ST_CNT_RD: state_d = ST_CNT_ADD;
			ST_CNT_ADD: begin
				if (status.i_last) begin
					state_d = ST_SC_SQ;
					side_d  = SIDE_FULL;
				end else begin
					state_d = ST_CNT_RD;
				end
			end
			ST_SC_SQ: state_d = ST_SC_NUM;
			ST_SC_NUM: state_d = ST_SC_DIV;
			ST_SC_DIV: begin
				if (status.div_last) state_d = ST_SC_END;
			end
			ST_SC_END: begin
				case (side_q)
					SIDE_FULL: state_d = ST_SCAN_INIT;
					SIDE_LEFT: begin
						state_d = ST_SC_SQ;
						side_d  = SIDE_RIGHT;
					end
					default: state_d = ST_SCAN_CMP;
				endcase
			end
			ST_SCAN_INIT: state_d = ST_SCAN_CUR;
			ST_SCAN_CUR: state_d = ST_SCAN_RD;
			ST_SCAN_RD: state_d = ST_SCAN_UPD;
			ST_SCAN_UPD: begin
				if (status.same) begin
					state_d = status.scan_last ? ST_FINISH : ST_SCAN_RD;
				end else begin
					state_d = ST_SC_SQ;
					side_d  = SIDE_LEFT;
				end
			end
			ST_SCAN_CMP: state_d = status.scan_last ? ST_FINISH : ST_SCAN_RD;
			ST_FINISH: begin
				if (status.out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd.side = side_q;
		case (state_q)
			ST_LOAD:      cmd.op = OP_LOAD;
			ST_START:     cmd.op = OP_START;
			ST_SORT_RDI:  cmd.op = OP_SORT_RDI;
			ST_SORT_KEY:  cmd.op = OP_SORT_KEY;
			ST_SORT_RDJ:  cmd.op = OP_SORT_RDJ;
			ST_SORT_CMP:  cmd.op = OP_SORT_CMP;
			ST_CNT_RD:    cmd.op = OP_CNT_RD;
			ST_CNT_ADD:   cmd.op = OP_CNT_ADD;
			ST_SC_SQ:     cmd.op = OP_SC_SQ;
			ST_SC_NUM:    cmd.op = OP_SC_NUM;
			ST_SC_DIV:    cmd.op = OP_SC_DIV;
			ST_SC_END:    cmd.op = OP_SC_END;
			ST_SCAN_INIT: cmd.op = OP_SCAN_INIT;
			ST_SCAN_CUR:  cmd.op = OP_SCAN_CUR;
			ST_SCAN_RD:   cmd.op = OP_SCAN_RD;
			ST_SCAN_UPD:  cmd.op = OP_SCAN_UPD;
			ST_SCAN_CMP:  cmd.op = OP_SCAN_CMP;
			ST_FINISH:    cmd.op = status.out_free ? OP_FINISH : OP_NONE;
			default:      cmd.op = OP_NONE;
		endcase
	end
endmodule

### hw/rtl/gbs_datapath.sv
// Sample memory, class counters, Gini score unit with serial divider, and result register.
module gbs_datapath #(
	parameter int MAX_SAMPLES = gbs_pkg::MAX_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gbs_pkg::dp_cmd_t                  cmd,
	output gbs_pkg::dp_status_t               status,
	input  logic                              cfg_we,
	input  logic [gbs_pkg::CLASS_W-1:0]       cfg_wdata,
	gbs_sample_if.sink                        sample,
	gbs_result_if.source                      result
);
	import gbs_pkg::*;

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SQW = 2 * CW;
	localparam int PW  = CW + SQW;
	localparam int NW  = PW + FRAC_BITS;
	localparam int QW  = CW + FRAC_BITS;
	localparam int SW  = QW + 1;
	localparam int DCW = $clog2(NW + 1);
	localparam int EW  = (SW > SCORE_OUT_W) ? SW : SCORE_OUT_W;

	entry_t mem [MAX_SAMPLES];
	entry_t rd_q, key_q, cur_q, nxt_q, in_entry, mem_wd;
	logic [AW-1:0] mem_wa, mem_ra;
	logic mem_we, mem_re;

	logic [CLASS_W-1:0] class_count_q;
	logic [CW-1:0] cnt_q;
	logic ovf_q, bad_q;
	logic [AW-1:0] i_q, j_q, next_i;
	logic [DCW-1:0] dcnt_q;
	logic found_q, median_q, out_valid_q;
	logic [CW-1:0] cl_q [NUM_CLASSES];
	logic [CW-1:0] cr_q [NUM_CLASSES];
	logic [CW-1:0] sl_cnt_q, sr_cnt_q;
	logic [SQW-1:0] ql_q, qr_q;

	logic [SQW-1:0] sq_q;
	logic [SQW:0] den_q, rem_q;
	logic [NW-1:0] dq_q;
	logic [QW-1:0] full_q, sl_q, sr_q, score_res;
	logic [SW-1:0] best_q, med_score_q, g_sum, fin_best;
	logic signed [THR_W-1:0] best_sum_q, med_sum_q, pair_sum, fin_sum;

	logic out_found_q, out_ovf_q, out_bad_q;
	logic signed [THR_W-1:0] out_sum_q;
	logic [SCORE_OUT_W-1:0] out_imp_q, out_gain_q;

	logic fire, full, lab_ok_in, cnt_lab_ok, cur_lab_ok, fin_found;
	logic [CW-1:0] s_sel, m_sel;
	logic [SQW-1:0] q_sel;
	logic [PW-1:0] prod;
	logic [SQW+1:0] div_t;
	logic div_ge;
	logic [LABEL_W-1:0] cl_idx, cnt_lab;

	function automatic logic [SCORE_OUT_W-1:0] sat_out(input logic [SW-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		sat_out = (e > EW'({SCORE_OUT_W{1'b1}})) ? {SCORE_OUT_W{1'b1}} : e[SCORE_OUT_W-1:0];
	endfunction

	assign sample.ready = (cmd.op == OP_LOAD);
	assign fire = sample.valid && sample.ready;
	assign full = (cnt_q == CW'(MAX_SAMPLES));
	assign lab_ok_in = {1'b0, sample.class_label} < class_count_q;
	assign cnt_lab = rd_q.label;
	assign cnt_lab_ok = {1'b0, cnt_lab} < class_count_q;
	assign cl_idx = cur_q.label;
	assign cur_lab_ok = {1'b0, cl_idx} < class_count_q;

	always_comb begin
		in_entry.value = sample.feature_value;
		in_entry.label = sample.class_label;
	end

	always_comb begin
		status.last_fire = fire && sample.last_sample;
		status.n_lt2     = cnt_q < CW'(2);
		status.j_zero    = (j_q == '0);
		status.i_last    = (CW'(i_q) == cnt_q - CW'(1));
		status.shift     = $signed(rd_q.value) > $signed(key_q.value);
		status.same      = (cur_q.value == rd_q.value);
		status.scan_last = (CW'(i_q) == cnt_q - CW'(2));
		status.div_last  = (dcnt_q == DCW'(1));
		status.out_free  = !out_valid_q || result.ready;
	end

	assign next_i = status.i_last ? '0 : i_q + AW'(1);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = i_q;
		mem_wd = key_q;
		mem_re = 1'b0;
		mem_ra = i_q;
		case (cmd.op)
			OP_LOAD: begin
				mem_we = fire && !full;
				mem_wa = cnt_q[AW-1:0];
				mem_wd = in_entry;
			end
			OP_SORT_RDI: mem_re = 1'b1;
			OP_SORT_RDJ: begin
				if (status.j_zero) begin
					mem_we = 1'b1;
					mem_wa = '0;
				end else begin
					mem_re = 1'b1;
					mem_ra = j_q - AW'(1);
				end
			end
			OP_SORT_CMP: begin
				mem_we = 1'b1;
				mem_wa = j_q;
				mem_wd = status.shift ? rd_q : key_q;
			end
			OP_CNT_RD: mem_re = 1'b1;
			OP_SCAN_INIT: begin
				mem_re = 1'b1;
				mem_ra = '0;
			end
			OP_SCAN_RD: begin
				mem_re = 1'b1;
				mem_ra = i_q + AW'(1);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	always_comb begin
		case (cmd.side)
			SIDE_LEFT: begin
				s_sel = sl_cnt_q;
				q_sel = ql_q;
				m_sel = CW'(i_q) + CW'(1);
			end
			SIDE_RIGHT: begin
				s_sel = sr_cnt_q;
				q_sel = qr_q;
				m_sel = cnt_q - CW'(i_q) - CW'(1);
			end
			default: begin
				s_sel = sr_cnt_q;
				q_sel = qr_q;
				m_sel = cnt_q;
			end
		endcase
	end

	assign prod      = PW'(m_sel) * PW'(sq_q - q_sel);
	assign div_t     = {rem_q, dq_q[NW-1]};
	assign div_ge    = div_t >= {1'b0, den_q};
	assign score_res = (den_q == '0) ? '0 : dq_q[QW-1:0];
	assign g_sum     = SW'(sl_q) + SW'(sr_q);
	assign pair_sum  = THR_W'($signed(cur_q.value)) + THR_W'($signed(nxt_q.value));
	assign fin_found = found_q || median_q;
	assign fin_best  = found_q ? best_q : med_score_q;
	assign fin_sum   = found_q ? best_sum_q : med_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CLASS_COUNT_RESET;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
			bad_q         <= 1'b0;
			i_q           <= '0;
			j_q           <= '0;
			dcnt_q        <= '0;
			found_q       <= 1'b0;
			median_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			sl_cnt_q      <= '0;
			sr_cnt_q      <= '0;
			ql_q          <= '0;
			qr_q          <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				cl_q[c] <= '0;
				cr_q[c] <= '0;
			end
		end else begin
			if (cfg_we) class_count_q <= cfg_wdata;
			if (cmd.op == OP_FINISH) out_valid_q <= 1'b1;
			else if (result.valid && result.ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					if (fire) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CW'(1);
							if (!lab_ok_in) bad_q <= 1'b1;
						end
					end
				end
				OP_START: begin
					i_q      <= AW'(1);
					found_q  <= 1'b0;
					median_q <= 1'b0;
					sl_cnt_q <= '0;
					sr_cnt_q <= '0;
					ql_q     <= '0;
					qr_q     <= '0;
					for (int c = 0; c < NUM_CLASSES; c++) begin
						cl_q[c] <= '0;
						cr_q[c] <= '0;
					end
				end
				OP_SORT_RDI: j_q <= i_q;
				OP_SORT_RDJ: begin
					if (status.j_zero) i_q <= next_i;
				end
				OP_SORT_CMP: begin
					if (status.shift) j_q <= j_q - AW'(1);
					else i_q <= next_i;
				end
				OP_CNT_ADD: begin
					i_q <= next_i;
					if (cnt_lab_ok) begin
						cr_q[cnt_lab] <= cr_q[cnt_lab] + CW'(1);
						sr_cnt_q      <= sr_cnt_q + CW'(1);
						qr_q          <= qr_q + SQW'({cr_q[cnt_lab], 1'b1});
					end
				end
				OP_SC_NUM: dcnt_q <= DCW'(NW);
				OP_SC_DIV: dcnt_q <= dcnt_q - DCW'(1);
				OP_SCAN_UPD: begin
					if (cur_lab_ok) begin
						cl_q[cl_idx] <= cl_q[cl_idx] + CW'(1);
						cr_q[cl_idx] <= cr_q[cl_idx] - CW'(1);
						sl_cnt_q     <= sl_cnt_q + CW'(1);
						sr_cnt_q     <= sr_cnt_q - CW'(1);
						ql_q         <= ql_q + SQW'({cl_q[cl_idx], 1'b1});
						qr_q         <= qr_q - SQW'({cr_q[cl_idx] - CW'(1), 1'b1});
					end
					if (status.same) i_q <= i_q + AW'(1);
				end
				OP_SCAN_CMP: begin
					i_q <= i_q + AW'(1);
					if (g_sum < best_q) found_q <= 1'b1;
					if (!median_q && (CW'(i_q) > (cnt_q >> 1))) median_q <= 1'b1;
				end
				OP_FINISH: begin
					cnt_q       <= '0;
					ovf_q       <= 1'b0;
					bad_q       <= 1'b0;
				end
				default: dcnt_q <= dcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				best_sum_q <= '0;
				med_sum_q  <= '0;
			end
			OP_SORT_KEY: key_q <= rd_q;
			OP_SC_SQ: sq_q <= SQW'(s_sel) * SQW'(s_sel);
			OP_SC_NUM: begin
				dq_q  <= {prod, {FRAC_BITS{1'b0}}};
				den_q <= {sq_q, 1'b0};
				rem_q <= '0;
			end
			OP_SC_DIV: begin
				rem_q <= div_ge ? (SQW+1)'(div_t - {1'b0, den_q}) : div_t[SQW:0];
				dq_q  <= {dq_q[NW-2:0], div_ge};
			end
			OP_SC_END: begin
				case (cmd.side)
					SIDE_FULL: begin
						full_q <= score_res;
						best_q <= SW'(score_res);
					end
					SIDE_LEFT: sl_q <= score_res;
					default:   sr_q <= score_res;
				endcase
			end
			OP_SCAN_CUR: cur_q <= rd_q;
			OP_SCAN_UPD: begin
				nxt_q <= rd_q;
				if (status.same) cur_q <= rd_q;
			end
			OP_SCAN_CMP: begin
				cur_q <= nxt_q;
				if (g_sum < best_q) begin
					best_q     <= g_sum;
					best_sum_q <= pair_sum;
				end
				if (!median_q && (CW'(i_q) > (cnt_q >> 1))) begin
					med_score_q <= g_sum;
					med_sum_q   <= pair_sum;
				end
			end
			OP_FINISH: begin
				out_found_q <= fin_found;
				out_ovf_q   <= ovf_q;
				out_bad_q   <= bad_q;
				out_sum_q   <= fin_found ? fin_sum : '0;
				out_imp_q   <= fin_found ? sat_out(fin_best) : '0;
				out_gain_q  <= (fin_found && (SW'(full_q) > fin_best))
					? sat_out(SW'(full_q) - fin_best) : '0;
			end
			default: key_q <= key_q;
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.split_found   = out_found_q;
	assign result.threshold_sum = out_sum_q;
	assign result.best_impurity = out_imp_q;
	assign result.split_gain    = out_gain_q;
	assign result.overflowed    = out_ovf_q;
	assign result.bad_label     = out_bad_q;
endmodule

### hw/rtl/gini_best_split_search.sv
// Loading accepts one sample transaction per cycle; the node search starts after the last one.
// Insertion sort in the sample memory moves each sample past the larger entries before it,
// then counting tallies the labels, the node score is taken, and each distinct boundary
// scores its left and right sides, with the divider producing one quotient bit per cycle over a
// dividend of NW = 3*ceil(log2(MAX_SAMPLES+1))+16 bits (43 by default).
// One node is searched at a time; reset clears control state and sets class_count to 2.
module gini_best_split_search #(
	parameter int MAX_SAMPLES = gbs_pkg::MAX_SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	gbs_sample_if.sink                  sample,
	gbs_result_if.source                result,
	input  logic                        cfg_we,
	input  logic [gbs_pkg::CLASS_W-1:0] cfg_wdata
);
	import gbs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	gbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	gbs_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (sample),
		.result    (result)
	);
endmodule
